### sv/quaternion_to_euler_angles_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle block.
// Both sample on the rising edge of clk; the first is quiet during reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Property checked only while rst_n is high.
`define Q2E_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property checked at every edge, reset included.
`define Q2E_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### sv/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Types and constants shared by the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

  localparam int QW       = 32;  // input fields, Q2.30
  localparam int PW       = 34;  // product shifted back to Q.30
  localparam int OW       = 36;  // atan2 operands after sums and doubling
  localparam int XW       = 40;  // CORDIC x and y, room for the gain
  localparam int ZW       = 32;  // angle, radians scaled by 2^24
  localparam int SQW      = 61;  // square root radicand, at most 2^60
  localparam int RW       = 62;  // square root work register
  localparam int SQ_STEPS = 31;  // one result bit per stage
  localparam int TAB_LEN  = 24;
  localparam int OFFW     = 13;
  localparam int AW       = 16;

  localparam logic signed [ZW-1:0] HALF_PI_Z = 32'sd26353589;

  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331,
    32'sd1047214,  32'sd524117,  32'sd262123,  32'sd131069,
    32'sd65536,    32'sd32768,   32'sd16384,   32'sd8192,
    32'sd4096,     32'sd2048,    32'sd1024,    32'sd512,
    32'sd256,      32'sd128,     32'sd64,      32'sd32,
    32'sd16,       32'sd8,       32'sd4,       32'sd2
  };

  // Degrees times 128 is z * 73344 / (10 * 2^24), rounded half up.
  localparam logic signed [17:0] DEG_NUM     = 18'sd73344;
  localparam logic signed [49:0] DEG_HALF    = 50'sd83886080;
  localparam logic signed [22:0] DIV_BIAS    = 23'sd2621440;   // 10 * 2^18
  localparam logic signed [20:0] DIV_BIAS_Q  = 21'sd262144;    // DIV_BIAS / 10
  localparam logic [22:0]        RECIP_TEN   = 23'd6710887;    // ceil(2^26 / 10)

  localparam logic signed [OFFW-1:0] PITCH_OFF_RST = 13'sd128;
  localparam logic signed [OFFW-1:0] ROLL_OFF_RST  = -13'sd256;
  localparam logic signed [OFFW-1:0] YAW_OFF_RST   = 13'sd0;

  typedef enum logic [1:0] {
    CFG_PITCH = 2'd0,
    CFG_ROLL  = 2'd1,
    CFG_YAW   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } in_data_t;

  typedef struct packed {
    logic signed [AW-1:0] pitch_angle;
    logic signed [AW-1:0] roll_angle;
    logic signed [AW-1:0] yaw_angle;
  } out_data_t;

  // Operands of the three angle computations, carried beside the square root.
  typedef struct packed {
    logic signed [QW-1:0] s;
    logic signed [OW-1:0] ra;
    logic signed [OW-1:0] rb;
    logic signed [OW-1:0] ya;
    logic signed [OW-1:0] yb;
  } ang_ops_t;

endpackage

`default_nettype wire

### sv/q2e_sqrt.sv
// ----------------------------------------------------------------------------
// q2e_sqrt
// Pipelined integer square root, one result bit per stage, with the
// angle operands travelling alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [q2e_pkg::SQW-1:0]            rad,
  input  wire q2e_pkg::ang_ops_t                  ops_in,
  output logic [q2e_pkg::SQ_STEPS-1:0]            root,
  output q2e_pkg::ang_ops_t                       ops_out
);

  logic [q2e_pkg::SQW-1:0] v_r   [q2e_pkg::SQ_STEPS];
  logic [q2e_pkg::RW-1:0]  r_r   [q2e_pkg::SQ_STEPS];
  q2e_pkg::ang_ops_t       ops_r [q2e_pkg::SQ_STEPS];

  genvar j;
  generate
    for (j = 0; j < q2e_pkg::SQ_STEPS; j++) begin : g_step
      localparam int SH = 2 * (q2e_pkg::SQ_STEPS - 1 - j);
      logic [q2e_pkg::SQW-1:0] v_prev, v_nxt;
      logic [q2e_pkg::RW-1:0]  r_prev, r_nxt, trial, bitv;
      q2e_pkg::ang_ops_t       ops_prev;

      if (j == 0) begin : g_first
        assign v_prev   = rad;
        assign r_prev   = '0;
        assign ops_prev = ops_in;
      end else begin : g_next
        assign v_prev   = v_r[j-1];
        assign r_prev   = r_r[j-1];
        assign ops_prev = ops_r[j-1];
      end

      always_comb begin
        bitv  = q2e_pkg::RW'(1) << SH;
        trial = r_prev + bitv;
        if ({1'b0, v_prev} >= trial) begin
          v_nxt = v_prev - trial[q2e_pkg::SQW-1:0];
          r_nxt = (r_prev >> 1) + bitv;
        end else begin
          v_nxt = v_prev;
          r_nxt = r_prev >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          v_r[j]   <= v_nxt;
          r_r[j]   <= r_nxt;
          ops_r[j] <= ops_prev;
        end
      end
    end
  endgenerate

  assign root    = r_r[q2e_pkg::SQ_STEPS-1][q2e_pkg::SQ_STEPS-1:0];
  assign ops_out = ops_r[q2e_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

### sv/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2: a quadrant stage, then one
// micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [q2e_pkg::XW-1:0]     x_in,
  input  wire logic signed [q2e_pkg::XW-1:0]     y_in,
  output logic signed [q2e_pkg::ZW-1:0]          z_out
);

  logic signed [q2e_pkg::XW-1:0] x_r [STAGES+1];
  logic signed [q2e_pkg::XW-1:0] y_r [STAGES+1];
  logic signed [q2e_pkg::ZW-1:0] z_r [STAGES+1];
  logic                          zf_r [STAGES+1];

  logic signed [q2e_pkg::XW-1:0] x0_nxt, y0_nxt;
  logic signed [q2e_pkg::ZW-1:0] z0_nxt;

  // A vector in the left half plane is turned by a quarter turn first.
  always_comb begin
    x0_nxt = x_in;
    y0_nxt = y_in;
    z0_nxt = '0;
    if (x_in[q2e_pkg::XW-1]) begin
      if (!y_in[q2e_pkg::XW-1]) begin
        x0_nxt = y_in;
        y0_nxt = -x_in;
        z0_nxt = q2e_pkg::HALF_PI_Z;
      end else begin
        x0_nxt = -y_in;
        y0_nxt = x_in;
        z0_nxt = -q2e_pkg::HALF_PI_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0_nxt;
      y_r[0]  <= y0_nxt;
      z_r[0]  <= z0_nxt;
      zf_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  genvar i;
  generate
    for (i = 1; i <= STAGES; i++) begin : g_rot
      logic signed [q2e_pkg::XW-1:0] dx, dy, x_nxt, y_nxt;
      logic signed [q2e_pkg::ZW-1:0] z_nxt;

      always_comb begin
        dx = y_r[i-1] >>> (i - 1);
        dy = x_r[i-1] >>> (i - 1);
        if (!y_r[i-1][q2e_pkg::XW-1]) begin
          x_nxt = x_r[i-1] + dx;
          y_nxt = y_r[i-1] - dy;
          z_nxt = z_r[i-1] + q2e_pkg::ATAN_TAB[i-1];
        end else begin
          x_nxt = x_r[i-1] - dx;
          y_nxt = y_r[i-1] + dy;
          z_nxt = z_r[i-1] - q2e_pkg::ATAN_TAB[i-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i]  <= x_nxt;
          y_r[i]  <= y_nxt;
          z_r[i]  <= z_nxt;
          zf_r[i] <= zf_r[i-1];
        end
      end
    end
  endgenerate

  // With both operands zero the angle is defined as zero.
  assign z_out = zf_r[STAGES] ? '0 : z_r[STAGES];

endmodule

`default_nettype wire

### sv/quaternion_to_euler_angles.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits on out_ready.
// Stages: products, sums, square, 31 square root steps, quadrant step,
// CORDIC_STAGES rotations, three scaling steps.
// Reset clears the valid bits and loads the offset registers; no clearing pass.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q2.30 attitude quaternion to pitch, roll and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire q2e_pkg::in_data_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output q2e_pkg::out_data_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [q2e_pkg::OFFW-1:0]      cfg_wdata
);

  localparam int LAT = 38 + CORDIC_STAGES;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Offset registers.
  logic signed [q2e_pkg::OFFW-1:0] pitch_off_r, roll_off_r, yaw_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_off_r <= q2e_pkg::PITCH_OFF_RST;
      roll_off_r  <= q2e_pkg::ROLL_OFF_RST;
      yaw_off_r   <= q2e_pkg::YAW_OFF_RST;
    end else if (cfg_we) begin
      unique case (q2e_pkg::cfg_idx_t'(cfg_index))
        q2e_pkg::CFG_PITCH: pitch_off_r <= cfg_wdata;
        q2e_pkg::CFG_ROLL:  roll_off_r  <= cfg_wdata;
        q2e_pkg::CFG_YAW:   yaw_off_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Product of two Q2.30 values, floored back to Q.30.
  function automatic logic signed [q2e_pkg::PW-1:0] mulq(
    input logic signed [q2e_pkg::QW-1:0] a,
    input logic signed [q2e_pkg::QW-1:0] b
  );
    logic signed [63:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  function automatic logic signed [q2e_pkg::OW-1:0] ext(
    input logic signed [q2e_pkg::PW-1:0] a
  );
    return {{(q2e_pkg::OW-q2e_pkg::PW){a[q2e_pkg::PW-1]}}, a};
  endfunction

  // Stage 1: products.
  logic signed [q2e_pkg::PW-1:0] ww_r, xx_r, yy_r, zz_r, wy_r, xz_r, yz_r, wx_r, xy_r, wz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= mulq(in_data.quat_w, in_data.quat_w);
      xx_r <= mulq(in_data.quat_x, in_data.quat_x);
      yy_r <= mulq(in_data.quat_y, in_data.quat_y);
      zz_r <= mulq(in_data.quat_z, in_data.quat_z);
      wy_r <= mulq(in_data.quat_w, in_data.quat_y);
      xz_r <= mulq(in_data.quat_x, in_data.quat_z);
      yz_r <= mulq(in_data.quat_y, in_data.quat_z);
      wx_r <= mulq(in_data.quat_w, in_data.quat_x);
      xy_r <= mulq(in_data.quat_x, in_data.quat_y);
      wz_r <= mulq(in_data.quat_w, in_data.quat_z);
    end
  end

  // Stage 2: sums, and the asin argument clamped to one.
  localparam logic signed [q2e_pkg::OW-1:0] ONE_Q30 = 36'sd1073741824;

  logic signed [q2e_pkg::OW-1:0] s_raw;
  q2e_pkg::ang_ops_t ops2_nxt, ops2_r;

  always_comb begin
    s_raw       = (ext(wy_r) - ext(xz_r)) <<< 1;
    ops2_nxt.ra = (ext(yz_r) + ext(wx_r)) <<< 1;
    ops2_nxt.rb = ONE_Q30 - ((ext(xx_r) + ext(yy_r)) <<< 1);
    ops2_nxt.ya = (ext(xy_r) + ext(wz_r)) <<< 1;
    ops2_nxt.yb = ext(ww_r) + ext(xx_r) - ext(yy_r) - ext(zz_r);
    if (s_raw > ONE_Q30) begin
      ops2_nxt.s = ONE_Q30[q2e_pkg::QW-1:0];
    end else if (s_raw < -ONE_Q30) begin
      ops2_nxt.s = -ONE_Q30[q2e_pkg::QW-1:0];
    end else begin
      ops2_nxt.s = s_raw[q2e_pkg::QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops2_r <= ops2_nxt;
    end
  end

  // Stage 3: square of the asin argument.
  logic signed [63:0] ssq_full;
  logic [q2e_pkg::SQW-1:0] ssq_r;
  q2e_pkg::ang_ops_t ops3_r;

  assign ssq_full = ops2_r.s * ops2_r.s;

  always_ff @(posedge clk) begin
    if (en) begin
      ssq_r  <= ssq_full[q2e_pkg::SQW-1:0];
      ops3_r <= ops2_r;
    end
  end

  // The cosine of pitch is sqrt(1 - s^2), all in Q.60 under the root.
  logic [q2e_pkg::SQW-1:0] rad;
  logic [q2e_pkg::SQ_STEPS-1:0] root;
  q2e_pkg::ang_ops_t ops_sq;

  assign rad = (q2e_pkg::SQW'(1) << 60) - ssq_r;

  q2e_sqrt u_sqrt (
    .clk     (clk),
    .en      (en),
    .rad     (rad),
    .ops_in  (ops3_r),
    .root    (root),
    .ops_out (ops_sq)
  );

  logic signed [q2e_pkg::XW-1:0] cx [3];
  logic signed [q2e_pkg::XW-1:0] cy [3];
  logic signed [q2e_pkg::ZW-1:0] cz [3];
  logic signed [q2e_pkg::OFFW-1:0] off_w [3];
  logic signed [q2e_pkg::AW-1:0] ang_r [3];

  assign cx[0] = {{(q2e_pkg::XW-q2e_pkg::SQ_STEPS){1'b0}}, root};
  assign cy[0] = {{(q2e_pkg::XW-q2e_pkg::QW){ops_sq.s[q2e_pkg::QW-1]}}, ops_sq.s};
  assign cx[1] = {{(q2e_pkg::XW-q2e_pkg::OW){ops_sq.rb[q2e_pkg::OW-1]}}, ops_sq.rb};
  assign cy[1] = {{(q2e_pkg::XW-q2e_pkg::OW){ops_sq.ra[q2e_pkg::OW-1]}}, ops_sq.ra};
  assign cx[2] = {{(q2e_pkg::XW-q2e_pkg::OW){ops_sq.yb[q2e_pkg::OW-1]}}, ops_sq.yb};
  assign cy[2] = {{(q2e_pkg::XW-q2e_pkg::OW){ops_sq.ya[q2e_pkg::OW-1]}}, ops_sq.ya};

  assign off_w[0] = pitch_off_r;
  assign off_w[1] = roll_off_r;
  assign off_w[2] = yaw_off_r;

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_ang
      logic signed [49:0] deg_nxt, deg_r, deg_sum;
      logic signed [19:0] t;
      logic signed [22:0] u_sum;
      logic [21:0]        u;
      logic [44:0]        quo_nxt, quo_r;
      logic signed [20:0] q_off;
      logic signed [q2e_pkg::AW-1:0] ang_nxt;

      q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk   (clk),
        .en    (en),
        .x_in  (cx[k]),
        .y_in  (cy[k]),
        .z_out (cz[k])
      );

      assign deg_nxt = cz[k] * q2e_pkg::DEG_NUM;

      // Floor division by 10 * 2^24: a shift, then a biased multiply by the
      // reciprocal of ten so that the operand is never negative.
      always_comb begin
        deg_sum = deg_r + q2e_pkg::DEG_HALF;
        t       = deg_sum[43:24];
        u_sum   = {{3{t[19]}}, t} + q2e_pkg::DIV_BIAS;
        u       = u_sum[21:0];
        quo_nxt = u * q2e_pkg::RECIP_TEN;
      end

      always_comb begin
        q_off = $signed({2'b00, quo_r[44:26]}) - q2e_pkg::DIV_BIAS_Q
              + {{(21-q2e_pkg::OFFW){off_w[k][q2e_pkg::OFFW-1]}}, off_w[k]};
        if (q_off > 21'sd32767) begin
          ang_nxt = 16'sh7fff;
        end else if (q_off < -21'sd32768) begin
          ang_nxt = 16'sh8000;
        end else begin
          ang_nxt = q_off[q2e_pkg::AW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          deg_r    <= deg_nxt;
          quo_r    <= quo_nxt;
          ang_r[k] <= ang_nxt;
        end
      end
    end
  endgenerate

  assign out_data.pitch_angle = ang_r[0];
  assign out_data.roll_angle  = ang_r[1];
  assign out_data.yaw_angle   = ang_r[2];

endmodule

`default_nettype wire

### sv/q2e_port_checker.sv
// ----------------------------------------------------------------------------
// q2e_port_checker
// Port-level checks of the quaternion to Euler angle block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"

module q2e_port_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire q2e_pkg::out_data_t out_data
);

  `Q2E_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `Q2E_ASSERT(a_stall_blocks_in, out_valid && !out_ready |-> !in_ready)
  `Q2E_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
  `Q2E_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind quaternion_to_euler_angles q2e_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
